// File: src/krt_pkg.sv
// Shared types and codes for the keyed record table.
// No dependencies; every other file in src except krt_if imports this package.
package krt_pkg;

   // Default table depth
   localparam int DEPTH_DEFAULT = 64;

   // Request kinds
   localparam logic [2:0] KIND_ADD    = 3'd0;
   localparam logic [2:0] KIND_SEARCH = 3'd1;
   localparam logic [2:0] KIND_UPDATE = 3'd2;
   localparam logic [2:0] KIND_DELETE = 3'd3;
   localparam logic [2:0] KIND_DUMP   = 3'd4;

   // Response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   // One table record
   typedef struct packed {
      logic signed [31:0] key;
      logic [31:0]        name;
      logic [15:0]        mark;
   } record_type;

   // Controller to ring: shift strobe and the record entering the tail cell
   typedef struct packed {
      logic       shift_en;
      record_type tail_rec;
   } ring_ctl_type;

endpackage

// File: src/krt_if.sv
// Valid/ready channel interfaces for requests and responses.
// No dependencies.
interface krt_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [31:0] key;
   logic [31:0]        name_handle;
   logic [15:0]        mark;

   modport source (output valid, kind, key, name_handle, mark, input ready);
   modport sink   (input valid, kind, key, name_handle, mark, output ready);
endinterface

interface krt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] found_key;
   logic [31:0]        found_name;
   logic [15:0]        found_mark;
   logic               last;

   modport source (output valid, status, found_key, found_name, found_mark, last,
                   input ready);
   modport sink   (input valid, status, found_key, found_name, found_mark, last,
                   output ready);
endinterface

// File: src/krt_cell.sv
// One storage cell of the record ring: holds a record and takes its
// neighbor's record on every shift. Depends on krt_pkg.
module krt_cell
   import krt_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  record_type shift_in,
   output record_type rec_out
);

   record_type rec_ff;

   // Shift register stage, no reset (contents are undefined until written)
   always_ff @(posedge clock) begin
      if (shift_en) begin
         rec_ff <= shift_in;
      end
   end

   assign rec_out = rec_ff;

endmodule

// File: src/krt_ctrl.sv
// Sequencer for the record ring: walks one full rotation per request,
// edits the stream at the tail and drives the response register.
// Depends on krt_pkg and krt_if.
module krt_ctrl
   import krt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   krt_req_if.sink       req,
   krt_rsp_if.source     rsp,
   input  record_type    head_rec,
   input  record_type    next_rec,
   output ring_ctl_type  ring_ctl
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {S_IDLE, S_RUN} state_type;

   typedef struct packed {
      logic [2:0] kind;
      record_type rec;
   } op_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   op_type            op_ff, op_in;
   logic              hit_ff, hit_in;
   record_type        rec_ff, rec_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   record_type        rsp_rec_ff, rsp_rec_in;
   logic              rsp_last_ff, rsp_last_in;

   logic       head_live, key_hit, first_hit, last_step, is_dump, has_room;
   logic       dump_emit, end_emit, need_emit, out_free, advance, hit_now;
   record_type upd_rec, rec_now, tail_rec;

   always_comb begin
      // Head cell holds logical entry step_ff
      head_live = CNT_W'(step_ff) < count_ff;
      key_hit   = head_live && (head_rec.key == op_ff.rec.key);
      first_hit = key_hit && !hit_ff;
      last_step = step_ff == IDX_W'(DEPTH - 1);
      is_dump   = op_ff.kind == KIND_DUMP;
      has_room  = count_ff != CNT_W'(DEPTH);

      upd_rec      = head_rec;
      upd_rec.name = op_ff.rec.name;
      upd_rec.mark = op_ff.rec.mark;

      hit_now = hit_ff || first_hit;
      rec_now = rec_ff;
      if (first_hit) begin
         rec_now = (op_ff.kind == KIND_UPDATE) ? upd_rec : head_rec;
      end

      // Emission points: every live entry on a non-empty dump, else once at the end (spare kinds never emit)
      dump_emit = is_dump && head_live;
      end_emit  = last_step && (op_ff.kind <= KIND_DUMP) && !(is_dump && count_ff != '0);
      need_emit = (state_ff == S_RUN) && (dump_emit || end_emit);
      out_free  = !rsp_valid_ff || rsp.ready;
      advance   = (state_ff == S_RUN) && (!need_emit || out_free);

      // Tail edit: what lands at logical index step_ff after the rotation
      tail_rec = head_rec;
      case (op_ff.kind)
         KIND_ADD: begin
            if (has_room && CNT_W'(step_ff) == count_ff) begin
               tail_rec = op_ff.rec;
            end
         end
         KIND_UPDATE: begin
            if (first_hit) begin
               tail_rec = upd_rec;
            end
         end
         KIND_DELETE: begin
            if (hit_now) begin
               tail_rec = next_rec;
            end
         end
         default: tail_rec = head_rec;
      endcase

      // Response payload
      rsp_status_in = STAT_OK;
      rsp_rec_in    = '0;
      rsp_last_in   = 1'b1;
      if (dump_emit) begin
         rsp_rec_in  = head_rec;
         rsp_last_in = (CNT_W'(step_ff) + CNT_W'(1)) == count_ff;
      end else begin
         case (op_ff.kind) inside
            KIND_ADD: begin
               if (has_room) begin
                  rsp_rec_in = op_ff.rec;
               end else begin
                  rsp_status_in = STAT_FULL;
               end
            end
            KIND_SEARCH, KIND_UPDATE, KIND_DELETE: begin
               if (hit_now) begin
                  rsp_rec_in = rec_now;
               end else begin
                  rsp_status_in = STAT_NOTFOUND;
               end
            end
            KIND_DUMP: rsp_status_in = STAT_EMPTY;
            default:   rsp_status_in = STAT_NOTFOUND;
         endcase
      end

      // Output register handoff
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (advance && need_emit) begin
         rsp_valid_in = 1'b1;
      end

      // Sequencing
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;
      op_in    = op_ff;
      hit_in   = hit_ff;
      rec_in   = rec_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in.kind     = req.kind;
               op_in.rec.key  = req.key;
               op_in.rec.name = req.name_handle;
               op_in.rec.mark = req.mark;
               hit_in         = 1'b0;
               step_in        = '0;
               state_in       = S_RUN;
            end
         end
         S_RUN: begin
            if (advance) begin
               hit_in  = hit_now;
               rec_in  = rec_now;
               step_in = step_ff + IDX_W'(1);
               if (last_step) begin
                  step_in  = '0;
                  state_in = S_IDLE;
                  if (op_ff.kind == KIND_ADD && has_room) begin
                     count_in = count_ff + CNT_W'(1);
                  end else if (op_ff.kind == KIND_DELETE && hit_now) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      rec_ff <= rec_in;
      if (advance && need_emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_rec_ff    <= rsp_rec_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign req.ready      = state_ff == S_IDLE;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.found_key  = rsp_rec_ff.key;
   assign rsp.found_name = rsp_rec_ff.name;
   assign rsp.found_mark = rsp_rec_ff.mark;
   assign rsp.last       = rsp_last_ff;

   assign ring_ctl.shift_en = advance;
   assign ring_ctl.tail_rec = tail_rec;

   // Fill count never passes the table depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   // Rotation counter rests at zero between requests
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> step_ff == '0)
      else $error("step counter not parked while idle");

   // The final rotation step always returns to idle
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      advance && last_step |=> state_ff == S_IDLE)
      else $error("sequencer did not finish after last step");

   // The fill count only moves at the end of a rotation
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && $past(state_ff == S_IDLE) |-> $stable(count_ff))
      else $error("entry count changed while idle");

   // A response is only produced by a running request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RUN))
      else $error("response raised without an active request");

endmodule

// File: src/keyed_record_table.sv
// Top level of the keyed record table: a ring of record cells and its sequencer.
// Depends on krt_pkg, krt_if, krt_cell and krt_ctrl.
//
//   channel  direction  handshake          payload
//   req      in         req.valid/ready    kind, key, name_handle, mark
//   rsp      out        rsp.valid/ready    status, found_key, found_name, found_mark, last
//
// Each request is accepted and then makes one full rotation of the DEPTH-cell ring,
// one cell per cycle unless a result stalls, as the head entry passes the comparator.
// A step that produces a result (each live entry on a dump, else the final step
// of a defined kind) holds while the previous result still waits.
// One response register decouples the sides; a new request is taken while it waits.
// Reset (synchronous) empties the table at once; cell contents are not cleared.
// Unused kinds rotate the ring and give no response.
module keyed_record_table
   import krt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   krt_req_if.sink   req,
   krt_rsp_if.source rsp
);

   record_type   cell_q [DEPTH];
   record_type   next_rec;
   ring_ctl_type ring_ctl;

   krt_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .head_rec (cell_q[0]),
      .next_rec (next_rec),
      .ring_ctl (ring_ctl)
   );

   // Ring of cells: each one takes its upper neighbor, the top takes the tail edit
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      record_type shift_in;
      if (i == DEPTH - 1) begin : g_tail
         assign shift_in = ring_ctl.tail_rec;
      end else begin : g_body
         assign shift_in = cell_q[i+1];
      end
      krt_cell u_cell (
         .clock    (clock),
         .shift_en (ring_ctl.shift_en),
         .shift_in (shift_in),
         .rec_out  (cell_q[i])
      );
   end

   // Entry behind the head, used to close the gap on a delete
   if (DEPTH > 1) begin : g_next
      assign next_rec = cell_q[1];
   end else begin : g_next_single
      assign next_rec = cell_q[0];
   end

endmodule

// File: bench/tb_keyed_record_table.sv
// Self-checking bench for keyed_record_table: requests from a queue, responses
// checked against an in-bench model of the record table and its dump ordering.
// Depends on krt_pkg, krt_if and the keyed_record_table RTL.
module tb_keyed_record_table
   import krt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = DEPTH_DEFAULT;
   localparam int QUIET_LIMIT = 5000;
   localparam int PRINT_LIMIT = 40;

   // Request kinds the block ignores
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [2:0]         kind;
      logic signed [31:0] key;
      logic [31:0]        name;
      logic [15:0]        mark;
   } request_type;

   typedef struct {
      logic [1:0] status;
      record_type rec;
      logic       last;
   } response_type;

   logic clock;
   logic reset;

   krt_req_if req_ch ();
   krt_rsp_if rsp_ch ();

   keyed_record_table #(.DEPTH(TABLE_DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Model state of the table
   record_type rec_store [TABLE_DEPTH];
   int         entry_count;
   int         peak_count;

   request_type   pending [$];
   response_type  expected [$];
   request_type   drive_item;

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int req_count;
   int rsp_count;
   int full_rejects;
   int dump_count;
   int quiet_cycles;

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Apply one accepted request to the table model and queue its responses
   task automatic predict_table(input request_type r);
      int           hit;
      int           i;
      response_type resp;
      hit = -1;
      resp.status = STAT_OK;
      resp.rec = '0;
      resp.last = 1'b1;
      for (i = entry_count - 1; i >= 0; i--) begin
         if (rec_store[i].key == r.key) hit = i;
      end
      case (r.kind) inside
         KIND_ADD: begin
            if (entry_count >= TABLE_DEPTH) begin
               resp.status = STAT_FULL;
               full_rejects++;
            end else begin
               rec_store[entry_count] = '{key: r.key, name: r.name, mark: r.mark};
               resp.rec = rec_store[entry_count];
               entry_count++;
               if (entry_count > peak_count) peak_count = entry_count;
            end
            expected.push_back(resp);
         end
         KIND_SEARCH, KIND_UPDATE, KIND_DELETE: begin
            if (hit < 0) begin
               resp.status = STAT_NOTFOUND;
            end else begin
               if (r.kind == KIND_UPDATE) begin
                  rec_store[hit].name = r.name;
                  rec_store[hit].mark = r.mark;
               end
               resp.rec = rec_store[hit];
               // delete closes the gap by shifting later records down
               if (r.kind == KIND_DELETE) begin
                  for (i = hit; i < entry_count - 1; i++) rec_store[i] = rec_store[i + 1];
                  entry_count--;
               end
            end
            expected.push_back(resp);
         end
         KIND_DUMP: begin
            dump_count++;
            if (entry_count == 0) begin
               resp.status = STAT_EMPTY;
               expected.push_back(resp);
            end else begin
               for (i = 0; i < entry_count; i++) begin
                  resp.rec = rec_store[i];
                  resp.last = (i == entry_count - 1);
                  expected.push_back(resp);
               end
            end
         end
         default: ;  // spare kinds: no response, no change
      endcase
   endtask

   task automatic check_response();
      response_type want;
      if (expected.size() == 0) begin
         report_mismatch("response with nothing outstanding");
         return;
      end
      want = expected.pop_front();
      if (rsp_ch.status !== want.status)
         report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
      if (rsp_ch.found_key !== want.rec.key)
         report_mismatch($sformatf("found_key got %h want %h",
                                   rsp_ch.found_key, want.rec.key));
      if (rsp_ch.found_name !== want.rec.name)
         report_mismatch($sformatf("found_name got %h want %h",
                                   rsp_ch.found_name, want.rec.name));
      if (rsp_ch.found_mark !== want.rec.mark)
         report_mismatch($sformatf("found_mark got %h want %h",
                                   rsp_ch.found_mark, want.rec.mark));
      if (rsp_ch.last !== want.last)
         report_mismatch($sformatf("last got %b want %b", rsp_ch.last, want.last));
   endtask

   function automatic request_type make_request(input logic [2:0] kind,
                                                input logic signed [31:0] key,
                                                input logic [31:0] name,
                                                input logic [15:0] mark);
      request_type r;
      r.kind = kind;
      r.key = key;
      r.name = name;
      r.mark = mark;
      return r;
   endfunction

   // Mostly a small pool of keys so lookups hit and duplicates pile up
   function automatic logic signed [31:0] pick_key();
      case ($urandom_range(11)) inside
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sd1;
         3: return 32'sd0;
         [4:6]: return $signed($urandom());
         default: return 32'sd1 + $urandom_range(4);
      endcase
   endfunction

   function automatic logic [15:0] pick_mark();
      case ($urandom_range(3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic request_type random_request(input int add_pct);
      logic [2:0] kind;
      int         sel;
      if ($urandom_range(99) < add_pct) begin
         kind = KIND_ADD;
      end else begin
         sel = $urandom_range(99);
         if (sel < 30)      kind = KIND_SEARCH;
         else if (sel < 55) kind = KIND_UPDATE;
         else if (sel < 85) kind = KIND_DELETE;
         else if (sel < 93) kind = KIND_DUMP;
         else               kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
      end
      return make_request(kind, pick_key(), $urandom(), pick_mark());
   endfunction

   // Pause until every queued request is taken and every response is back
   task automatic wait_drained();
      while (pending.size() != 0 || req_ch.valid || expected.size() != 0)
         @(negedge clock);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_item = pending.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.kind <= drive_item.kind;
            req_ch.key <= drive_item.key;
            req_ch.name_handle <= drive_item.name;
            req_ch.mark <= drive_item.mark;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            predict_table('{kind: req_ch.kind, key: req_ch.key,
                            name: req_ch.name_handle, mark: req_ch.mark});
            req_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_response();
            rsp_count++;
         end
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d responses outstanding",
                  QUIET_LIMIT, expected.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int n;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_ADD;
      req_ch.key = '0;
      req_ch.name_handle = '0;
      req_ch.mark = '0;
      rsp_ch.ready = 1'b0;
      entry_count = 0;
      peak_count = 0;
      error_count = 0;
      req_count = 0;
      rsp_count = 0;
      full_rejects = 0;
      dump_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 20;
      recv_idle_pct = 84;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, duplicates, shifting deletes, spare kinds
      pending.push_back(make_request(KIND_DUMP,   32'sd0, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_SEARCH, 32'sd5, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_UPDATE, 32'sd5, 32'h1111_2222, 16'h1234));
      pending.push_back(make_request(KIND_DELETE, 32'sd5, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_ADD, 32'sh8000_0000, 32'h0000_0000, 16'h0000));
      pending.push_back(make_request(KIND_ADD, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
      pending.push_back(make_request(KIND_ADD, -32'sd1, 32'h1234_5678, 16'd10000));
      pending.push_back(make_request(KIND_ADD, 32'sd0, 32'hA5A5_5A5A, 16'd9999));
      pending.push_back(make_request(KIND_ADD, -32'sd1, 32'hDEAD_BEEF, 16'd1));
      pending.push_back(make_request(KIND_SEARCH, -32'sd1, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_UPDATE, -32'sd1, 32'h0BAD_F00D, 16'h8000));
      pending.push_back(make_request(KIND_SEARCH, -32'sd1, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_DELETE, -32'sd1, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_SEARCH, -32'sd1, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_DUMP,   32'sd0, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_SPARE_FIRST, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
      pending.push_back(make_request(3'(KIND_SPARE_FIRST + 1), -32'sd1, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_SPARE_LAST, 32'sd0, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_DELETE, 32'sh8000_0000, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_DELETE, 32'sd0, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_SEARCH, 32'sh8000_0000, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_SEARCH, 32'sh7FFF_FFFE, 32'h0, 16'h0));
      pending.push_back(make_request(KIND_DUMP,   32'sd0, 32'h0, 16'h0));
      wait_drained();

      // Mixed traffic, sender mostly busy, receiver mostly stalled
      for (n = 0; n < 55; n++) pending.push_back(random_request(45));
      wait_drained();

      // Fill past the top, dump a full table, then add-heavy traffic
      send_idle_pct = 84;
      recv_idle_pct = 20;
      n = TABLE_DEPTH - entry_count + 2;
      repeat (n) pending.push_back(random_request(100));
      pending.push_back(make_request(KIND_DUMP, 32'sd0, 32'h0, 16'h0));
      for (n = 0; n < 20; n++) pending.push_back(random_request(60));
      wait_drained();

      // Back-to-back with no idling, delete-heavy to drain the table
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (n = 0; n < 60; n++) pending.push_back(random_request(20));
      pending.push_back(make_request(KIND_DUMP, 32'sd0, 32'h0, 16'h0));
      wait_drained();

      // Let a trailing spare-kind rotation finish; stray responses get flagged
      repeat (3 * (TABLE_DEPTH + 1)) @(posedge clock);

      $display("Ran %0d requests, checked %0d responses, %0d dumps", req_count, rsp_count,
               dump_count);
      $display("Table peaked at %0d of %0d entries, %0d adds rejected as full",
               peak_count, TABLE_DEPTH, full_rejects);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
